// File: design/acp_pkg.sv
// Package for the CAT240 record parser: payload types, phase codes, item codes.
// No dependencies.
`default_nettype none
package acp_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_datagram;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  item_code;
		logic [31:0] item_value;
		logic [2:0]  parse_status;
		logic        record_end;
	} out_item_t;

	typedef enum logic [4:0] {
		PH_CAT, PH_LENH, PH_LENL, PH_FS1, PH_FS2, PH_SRC, PH_TYPE, PH_INDEX,
		PH_SUMLEN, PH_SUMDATA, PH_NANO, PH_FEMTO, PH_RES, PH_CNT, PH_LOWREP,
		PH_MEDREP, PH_HIGHREP, PH_LOWDATA, PH_MEDDATA, PH_HIGHDATA, PH_TIME,
		PH_RELEN, PH_REDATA, PH_SPLEN, PH_SPDATA, PH_DONE, PH_ERR
	} phase_t;

	localparam logic [4:0] IC_SRC = 5'd0, IC_TYPE = 5'd1, IC_INDEX = 5'd2,
		IC_SUMLEN = 5'd3, IC_SUMBYTE = 5'd4, IC_NANO = 5'd5, IC_FEMTO = 5'd8,
		IC_RES = 5'd11, IC_NBVB = 5'd12, IC_NBCELLS = 5'd13, IC_VIDHDR = 5'd14,
		IC_VIDBYTE = 5'd15, IC_TIME = 5'd16, IC_RE = 5'd17, IC_SP = 5'd18,
		IC_STATUS = 5'd19;

	localparam logic [2:0] ST_OK = 3'd0, ST_SHORT = 3'd1, ST_CAT = 3'd2,
		ST_LEN = 3'd3, ST_FX = 3'd4, ST_MAND = 3'd5, ST_OVR = 3'd6;

	localparam int NFRN = 14;
	localparam logic [7:0] CATEGORY_RESET = 8'd240;

	// register index of the config port
	localparam logic REG_CATEGORY = 1'b0, REG_PASS = 1'b1;

	function automatic phase_t frn_head(input logic [3:0] k);
		case (k)
			4'd0: frn_head = PH_SRC;
			4'd1: frn_head = PH_TYPE;
			4'd2: frn_head = PH_INDEX;
			4'd3: frn_head = PH_SUMLEN;
			4'd4: frn_head = PH_NANO;
			4'd5: frn_head = PH_FEMTO;
			4'd6: frn_head = PH_RES;
			4'd7: frn_head = PH_CNT;
			4'd8: frn_head = PH_LOWREP;
			4'd9: frn_head = PH_MEDREP;
			4'd10: frn_head = PH_HIGHREP;
			4'd11: frn_head = PH_TIME;
			4'd12: frn_head = PH_RELEN;
			default: frn_head = PH_SPLEN;
		endcase
	endfunction

	function automatic logic [3:0] frn_size(input logic [3:0] k);
		case (k)
			4'd0, 4'd6: frn_size = 4'd2;
			4'd2: frn_size = 4'd4;
			4'd4, 4'd5: frn_size = 4'd12;
			4'd7: frn_size = 4'd5;
			4'd11: frn_size = 4'd3;
			default: frn_size = 4'd1;
		endcase
	endfunction
endpackage
`default_nettype wire

// File: design/acp_cfg.sv
// Configuration registers of the CAT240 parser behind an APB-style port.
// Depends on acp_pkg.
`default_nettype none
module acp_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [7:0]       expected_category,
	output logic             pass_payload
);
	import acp_pkg::*;
	logic [7:0] cat_q;
	logic pass_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cat_q <= CATEGORY_RESET;
			pass_q <= 1'b1;
		end else if (wr && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_CATEGORY) cat_q <= pwdata[7:0];
			else pass_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_CATEGORY) prdata = {24'd0, cat_q};
			else prdata = {31'd0, pass_q};
		end
	end

	assign expected_category = cat_q;
	assign pass_payload = pass_q;
endmodule
`default_nettype wire

// File: design/acp_step.sv
// One-byte parse step of the CAT240 parser: state update and up to two results.
// Depends on acp_pkg.
`default_nettype none
module acp_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  acp_pkg::in_item_t      in_item,
	input  wire logic [7:0]        expected_category,
	input  wire logic              pass_payload,
	output acp_pkg::out_item_t     res0,
	output acp_pkg::out_item_t     res1,
	output logic [1:0]             nres
);
	import acp_pkg::*;

	phase_t ph_q, ph_d;
	logic [15:0] seen_q, seen_d, blen_q, blen_d, rem_q, rem_d, pcnt_q, pcnt_d;
	logic [7:0] fs1_q, fs1_d, fs2_q, fs2_d;
	logic [3:0] fbc_q, fbc_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0] err_q, err_d;

	// first present FRN at or after k; sets ph_d / err_d
	function automatic void start_from(input logic [3:0] k, input logic [7:0] f1,
		input logic [7:0] f2, input logic [15:0] rem, inout phase_t ph,
		inout logic [2:0] er, inout logic [3:0] fbc, inout logic [31:0] acc);
		logic found;
		logic [7:0] fs;
		logic [7:0] bitm;
		found = 1'b0;
		ph = PH_DONE;
		for (int i = 0; i < NFRN; i++) begin
			fs = (i >= 7) ? f2 : f1;
			bitm = 8'h80 >> ((i >= 7) ? (i - 7) : i);
			if (!found && 4'(i) >= k && (fs & bitm) != 8'd0) begin
				found = 1'b1;
				if (rem < {12'd0, frn_size(4'(i))}) begin
					er = ST_OVR;
					ph = PH_ERR;
				end else begin
					ph = frn_head(4'(i));
					fbc = '0;
					acc = '0;
				end
			end
		end
	endfunction

	logic [7:0] b;
	logic [15:0] plen;
	logic [3:0] nxt;
	logic [4:0] base;
	logic [2:0] st;
	out_item_t r0, r1;
	logic [1:0] n;

	always_comb begin
		b = in_item.data_byte;
		ph_d = ph_q; seen_d = seen_q; blen_d = blen_q; rem_d = rem_q;
		pcnt_d = pcnt_q; fs1_d = fs1_q; fs2_d = fs2_q; fbc_d = fbc_q;
		acc_d = acc_q; err_d = err_q;
		r0 = '0; r1 = '0; n = 2'd0;
		plen = '0; nxt = '0; base = '0; st = ST_OK;

		if (seen_q != 16'hFFFF) seen_d = seen_q + 16'd1;
		if (ph_q >= PH_FS1 && ph_q < PH_DONE) begin
			if (rem_q != 16'd0) rem_d = rem_q - 16'd1;
			acc_d = {acc_q[23:0], b};
			fbc_d = fbc_q + 4'd1;
		end

		case (ph_q)
			PH_CAT: begin
				if (b != expected_category) begin err_d = ST_CAT; ph_d = PH_ERR; end
				else ph_d = PH_LENH;
			end
			PH_LENH: begin
				blen_d = {b, 8'd0};
				ph_d = PH_LENL;
			end
			PH_LENL: begin
				blen_d = {blen_q[15:8], b};
				if (blen_d < 16'd4) begin err_d = ST_LEN; ph_d = PH_ERR; end
				else begin rem_d = blen_d - 16'd3; ph_d = PH_FS1; end
			end
			PH_FS1: begin
				fs1_d = b;
				if (b[0]) begin
					if (rem_d == 16'd0) begin err_d = ST_OVR; ph_d = PH_ERR; end
					else ph_d = PH_FS2;
				end else if (b[7:6] != 2'b11) begin err_d = ST_MAND; ph_d = PH_ERR; end
				else start_from(4'd0, fs1_d, fs2_d, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_FS2: begin
				fs2_d = b;
				if (b[0]) begin err_d = ST_FX; ph_d = PH_ERR; end
				else if (fs1_q[7:6] != 2'b11) begin err_d = ST_MAND; ph_d = PH_ERR; end
				else start_from(4'd0, fs1_d, fs2_d, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_SRC: if (fbc_d == 4'd2) begin
				r0.item_code = IC_SRC; r0.item_value = acc_d; n = 2'd1;
				start_from(4'd1, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_TYPE: begin
				r0.item_code = IC_TYPE; r0.item_value = {24'd0, b}; n = 2'd1;
				start_from(4'd2, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_INDEX: if (fbc_d == 4'd4) begin
				r0.item_code = IC_INDEX; r0.item_value = acc_d; n = 2'd1;
				start_from(4'd3, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_SUMLEN, PH_RELEN, PH_SPLEN, PH_LOWREP, PH_MEDREP, PH_HIGHREP: begin
				case (ph_q)
					PH_SUMLEN: begin
						r0.item_code = IC_SUMLEN; r0.item_value = {24'd0, b};
						plen = {8'd0, b}; nxt = 4'd4;
					end
					PH_RELEN: begin
						r0.item_code = IC_RE; r0.item_value = {24'd0, b};
						plen = {8'd0, b}; nxt = 4'd13;
					end
					PH_SPLEN: begin
						r0.item_code = IC_SP; r0.item_value = {24'd0, b};
						plen = {8'd0, b}; nxt = 4'd14;
					end
					PH_LOWREP: begin
						r0.item_code = IC_VIDHDR; r0.item_value = {24'd0, b};
						plen = {6'd0, b, 2'd0}; nxt = 4'd9;
					end
					PH_MEDREP: begin
						r0.item_code = IC_VIDHDR; r0.item_value = {22'd0, 2'd1, b};
						plen = {2'd0, b, 6'd0}; nxt = 4'd10;
					end
					default: begin
						r0.item_code = IC_VIDHDR; r0.item_value = {22'd0, 2'd2, b};
						plen = {b, 8'd0}; nxt = 4'd11;
					end
				endcase
				n = 2'd1;
				pcnt_d = plen;
				if (plen == 16'd0)
					start_from(nxt, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
				else if (rem_d < plen) begin err_d = ST_OVR; ph_d = PH_ERR; end
				else begin
					case (ph_q)
						PH_SUMLEN: ph_d = PH_SUMDATA;
						PH_RELEN: ph_d = PH_REDATA;
						PH_SPLEN: ph_d = PH_SPDATA;
						PH_LOWREP: ph_d = PH_LOWDATA;
						PH_MEDREP: ph_d = PH_MEDDATA;
						default: ph_d = PH_HIGHDATA;
					endcase
				end
			end
			PH_SUMDATA, PH_LOWDATA, PH_MEDDATA, PH_HIGHDATA, PH_REDATA, PH_SPDATA: begin
				case (ph_q)
					PH_SUMDATA: begin nxt = 4'd4; r0.item_code = IC_SUMBYTE; end
					PH_LOWDATA: begin nxt = 4'd9; r0.item_code = IC_VIDBYTE; end
					PH_MEDDATA: begin nxt = 4'd10; r0.item_code = IC_VIDBYTE; end
					PH_HIGHDATA: begin nxt = 4'd11; r0.item_code = IC_VIDBYTE; end
					PH_REDATA: nxt = 4'd13;
					default: nxt = 4'd14;
				endcase
				r0.item_value = {24'd0, b};
				if (pass_payload && ph_q != PH_REDATA && ph_q != PH_SPDATA) n = 2'd1;
				pcnt_d = pcnt_q - 16'd1;
				if (pcnt_d == 16'd0)
					start_from(nxt, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_NANO, PH_FEMTO: if (fbc_d[1:0] == 2'd0) begin
				base = (ph_q == PH_NANO) ? IC_NANO : IC_FEMTO;
				r0.item_code = base + 5'(fbc_d[3:2]) - 5'd1;
				r0.item_value = acc_d; n = 2'd1;
				acc_d = '0;
				if (fbc_d == 4'd12)
					start_from((ph_q == PH_NANO) ? 4'd5 : 4'd6, fs1_q, fs2_q, rem_d,
						ph_d, err_d, fbc_d, acc_d);
			end
			PH_RES: if (fbc_d == 4'd2) begin
				r0.item_code = IC_RES; r0.item_value = acc_d; n = 2'd1;
				start_from(4'd7, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			PH_CNT: begin
				if (fbc_d == 4'd2) begin
					r0.item_code = IC_NBVB; r0.item_value = acc_d; n = 2'd1;
					acc_d = '0;
				end else if (fbc_d == 4'd5) begin
					r0.item_code = IC_NBCELLS; r0.item_value = acc_d; n = 2'd1;
					start_from(4'd8, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
				end
			end
			PH_TIME: if (fbc_d == 4'd3) begin
				r0.item_code = IC_TIME; r0.item_value = acc_d; n = 2'd1;
				start_from(4'd12, fs1_q, fs2_q, rem_d, ph_d, err_d, fbc_d, acc_d);
			end
			default: ;
		endcase

		if (in_item.end_of_datagram) begin
			if (seen_d < 16'd3) st = ST_SHORT;
			else if (err_d == ST_CAT) st = ST_CAT;
			else if (blen_d < 16'd4 || seen_d < blen_d) st = ST_LEN;
			else st = err_d;
			if (n == 2'd0) begin
				r0.item_code = IC_STATUS; r0.item_value = {16'd0, seen_d};
				r0.parse_status = st; r0.record_end = 1'b1;
			end else begin
				r1.item_code = IC_STATUS; r1.item_value = {16'd0, seen_d};
				r1.parse_status = st; r1.record_end = 1'b1;
			end
			n = n + 2'd1;
			ph_d = PH_CAT; seen_d = '0; blen_d = '0; rem_d = '0; fs1_d = '0;
			fs2_d = '0; fbc_d = '0; acc_d = '0; pcnt_d = '0; err_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_CAT; seen_q <= '0; blen_q <= '0; rem_q <= '0; pcnt_q <= '0;
			fs1_q <= '0; fs2_q <= '0; fbc_q <= '0; acc_q <= '0; err_q <= ST_OK;
		end else if (en) begin
			ph_q <= ph_d; seen_q <= seen_d; blen_q <= blen_d; rem_q <= rem_d;
			pcnt_q <= pcnt_d; fs1_q <= fs1_d; fs2_q <= fs2_d; fbc_q <= fbc_d;
			acc_q <= acc_d; err_q <= err_d;
		end
	end

	assign res0 = r0;
	assign res1 = r1;
	assign nres = n;
endmodule
`default_nettype wire

// File: design/acp_outq.sv
// Result queue of the CAT240 parser: 4-entry FIFO, takes up to two items a cycle.
// Depends on acp_pkg.
`default_nettype none
module acp_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  acp_pkg::out_item_t   w0,
	input  acp_pkg::out_item_t   w1,
	input  wire logic [1:0]      wn,
	output logic                 room2,
	output logic                 valid,
	input  wire logic            stall,
	output acp_pkg::out_item_t   rd
);
	import acp_pkg::*;
	out_item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic pop;
	logic [1:0] nin;

	assign valid = cnt_q != 3'd0;
	assign pop = valid & ~stall;
	assign rd = mem_q[rp_q];
	assign room2 = cnt_q <= 3'd2;
	assign nin = push ? wn : 2'd0;

	always_ff @(posedge clk) begin
		if (nin != 2'd0) mem_q[wp_q] <= w0;
		if (nin == 2'd2) mem_q[wp_q + 2'd1] <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + nin;
			rp_q <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, nin} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: design/asterix_cat240_record_parser_core.sv
// Top level of the CAT240 radar video record parser.
// Depends on acp_pkg, acp_cfg, acp_step, acp_outq.
//
// Usage:
//  in_valid/in_stall carry one datagram byte per item (in_item); the last
//  byte has end_of_datagram set. out_valid/out_stall carry decoded results.
//  One byte enters per cycle while in_stall is low. Each byte is parsed
//  in the cycle it is accepted, against the registered parse state, and
//  its zero, one or two results are registered into a four-entry result
//  queue when it is accepted; they reach out_item in order, after older ones.
//  Throughput: one byte per cycle while the receiver keeps up. A byte can
//  give two results (last item plus status), so when the queue holds more
//  than two results in_stall rises until the receiver drains it.
//  Reset clears parse state and queue and loads category 240 and
//  pass_payload 1. The APB port writes the two registers at 0x0 and 0x4;
//  write them only while the parser is idle.
`default_nettype none
module asterix_cat240_record_parser_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  acp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  wire logic          out_stall,
	output acp_pkg::out_item_t out_item,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import acp_pkg::*;

	logic [7:0] cat;
	logic pass;
	logic acc_in, room2;
	out_item_t r0, r1;
	logic [1:0] nr;

	acp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.expected_category(cat), .pass_payload(pass)
	);

	// accept only when two result slots are free
	assign in_stall = ~room2;
	assign acc_in = in_valid & room2;

	acp_step u_step (
		.clk, .arst_n, .en(acc_in), .in_item, .expected_category(cat),
		.pass_payload(pass), .res0(r0), .res1(r1), .nres(nr)
	);

	acp_outq u_q (
		.clk, .arst_n, .push(acc_in), .w0(r0), .w1(r1), .wn(nr), .room2,
		.valid(out_valid), .stall(out_stall), .rd(out_item)
	);

	// a byte carrying end of datagram always produces a status result
	a_eod: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && in_item.end_of_datagram |-> nr != 2'd0)
		else $error("end of datagram without status");
	// two results only on the final byte
	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && nr == 2'd2 |-> in_item.end_of_datagram)
		else $error("two results on a non-final byte");
	// status item always carries record_end
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.item_code == IC_STATUS |-> out_item.record_end)
		else $error("status without record_end");
endmodule
`default_nettype wire

// File: dv/asterix_cat240_record_parser_core_tb.sv
// Self-checking testbench for the CAT240 record parser core.
// Depends on acp_pkg and asterix_cat240_record_parser_core; a built-in
// byte-level parse predictor checks every result item in order.
`timescale 1ns / 100ps
`default_nettype none
module asterix_cat240_record_parser_core_tb;
	import acp_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_item;
	out_item_t out_item;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	asterix_cat240_record_parser_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register byte addresses
	localparam logic [2:0] ADDR_CATEGORY = 3'd0, ADDR_PASS = 3'd4;

	// predictor copy of registers and parse state
	logic [7:0] cat_reg;
	logic pass_reg;
	phase_t ph;
	logic [15:0] seen, blen, remain, pay_cnt;
	logic [7:0] fs1, fs2;
	logic [3:0] fcnt;
	logic [31:0] acc;
	logic [2:0] err;

	out_item_t expected_q[$];
	int errors;
	bit rx_idle_en, hold_rx;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic clear_parse();
		ph = PH_CAT; seen = 0; blen = 0; remain = 0; pay_cnt = 0;
		fs1 = 0; fs2 = 0; fcnt = 0; acc = 0; err = ST_OK;
	endtask

	function automatic bit frn_present(int k);
		logic [7:0] mask;
		mask = 8'h80 >> (k < 7 ? k : k - 7);
		return ((k < 7 ? fs1 : fs2) & mask) != 0;
	endfunction

	task automatic fail_with(logic [2:0] code);
		err = code; ph = PH_ERR;
	endtask

	task automatic next_field(int k);
		for (; k < NFRN; k++) begin
			if (frn_present(k)) begin
				if (remain < frn_size(4'(k))) begin
					fail_with(ST_OVR);
					return;
				end
				ph = frn_head(4'(k)); fcnt = 0; acc = 0;
				return;
			end
		end
		ph = PH_DONE;
	endtask

	task automatic open_payload(logic [15:0] len, phase_t data_ph, int nxt);
		pay_cnt = len;
		if (len == 0) next_field(nxt);
		else if (remain < len) fail_with(ST_OVR);
		else ph = data_ph;
	endtask

	task automatic close_fspec();
		if ((fs1 & 8'hC0) != 8'hC0) fail_with(ST_MAND);
		else next_field(0);
	endtask

	task automatic push_item(logic [4:0] code, logic [31:0] val,
			logic [2:0] st = ST_OK, logic fin = 1'b0);
		out_item_t r;
		r.item_code = code; r.item_value = val; r.parse_status = st; r.record_end = fin;
		expected_q.push_back(r);
	endtask

	// advance the parse predictor by one accepted byte
	task automatic predict_byte(in_item_t it);
		logic [7:0] b;
		phase_t cur;
		logic [2:0] st;
		int kind;
		logic [15:0] mult;
		b = it.data_byte;
		cur = ph;
		if (seen != 16'hFFFF) seen++;
		if (cur >= PH_FS1 && cur < PH_DONE) begin
			if (remain != 0) remain--;
			acc = {acc[23:0], b};
			fcnt = fcnt + 4'd1;
		end
		case (cur)
			PH_CAT: if (b != cat_reg) fail_with(ST_CAT); else ph = PH_LENH;
			PH_LENH: begin
				blen = {b, 8'h00}; ph = PH_LENL;
			end
			PH_LENL: begin
				blen[7:0] = b;
				if (blen < 4) fail_with(ST_LEN);
				else begin
					remain = blen - 16'd3; ph = PH_FS1;
				end
			end
			PH_FS1: begin
				fs1 = b;
				if (b[0]) begin
					if (remain == 0) fail_with(ST_OVR); else ph = PH_FS2;
				end else close_fspec();
			end
			PH_FS2: begin
				fs2 = b;
				if (b[0]) fail_with(ST_FX); else close_fspec();
			end
			PH_SRC: if (fcnt == 2) begin
				push_item(IC_SRC, acc); next_field(1);
			end
			PH_TYPE: begin
				push_item(IC_TYPE, b); next_field(2);
			end
			PH_INDEX: if (fcnt == 4) begin
				push_item(IC_INDEX, acc); next_field(3);
			end
			PH_SUMLEN: begin
				push_item(IC_SUMLEN, b); open_payload(b, PH_SUMDATA, 4);
			end
			PH_SUMDATA: begin
				if (pass_reg) push_item(IC_SUMBYTE, b);
				pay_cnt--;
				if (pay_cnt == 0) next_field(4);
			end
			PH_NANO, PH_FEMTO: if (fcnt[1:0] == 0) begin
				push_item((cur == PH_NANO ? IC_NANO : IC_FEMTO) + 5'(fcnt / 4) - 5'd1, acc);
				acc = 0;
				if (fcnt == 12) next_field(cur == PH_NANO ? 5 : 6);
			end
			PH_RES: if (fcnt == 2) begin
				push_item(IC_RES, acc); next_field(7);
			end
			PH_CNT: begin
				if (fcnt == 2) begin
					push_item(IC_NBVB, acc); acc = 0;
				end else if (fcnt == 5) begin
					push_item(IC_NBCELLS, acc); next_field(8);
				end
			end
			PH_LOWREP, PH_MEDREP, PH_HIGHREP: begin
				kind = int'(cur) - int'(PH_LOWREP);
				mult = kind == 0 ? 16'd4 : (kind == 1 ? 16'd64 : 16'd256);
				push_item(IC_VIDHDR, {22'd0, 2'(kind), b});
				open_payload(16'(b * mult), phase_t'(int'(PH_LOWDATA) + kind), 9 + kind);
			end
			PH_LOWDATA, PH_MEDDATA, PH_HIGHDATA: begin
				if (pass_reg) push_item(IC_VIDBYTE, b);
				pay_cnt--;
				if (pay_cnt == 0) next_field(9 + int'(cur) - int'(PH_LOWDATA));
			end
			PH_TIME: if (fcnt == 3) begin
				push_item(IC_TIME, acc); next_field(12);
			end
			PH_RELEN: begin
				push_item(IC_RE, b); open_payload(b, PH_REDATA, 13);
			end
			PH_REDATA: begin
				pay_cnt--;
				if (pay_cnt == 0) next_field(13);
			end
			PH_SPLEN: begin
				push_item(IC_SP, b); open_payload(b, PH_SPDATA, 14);
			end
			PH_SPDATA: begin
				pay_cnt--;
				if (pay_cnt == 0) next_field(14);
			end
			default: ;
		endcase
		if (it.end_of_datagram) begin
			if (seen < 3) st = ST_SHORT;
			else if (err == ST_CAT) st = ST_CAT;
			else if (blen < 4 || seen < blen) st = ST_LEN;
			else st = err;
			push_item(IC_STATUS, {16'd0, seen}, st, 1'b1);
			clear_parse();
		end
	endtask

	// offer one byte, hold it until accepted, then predict; valid stays up
	// between back-to-back bytes and drops only for an idle gap
	task automatic send_byte(logic [7:0] b, logic last, bit gaps = 1);
		if (gaps && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_item.data_byte <= b;
		in_item.end_of_datagram <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_byte('{data_byte: b, end_of_datagram: last});
		@(negedge clk);
	endtask

	task automatic send_bytes(logic [7:0] bytes[$], bit gaps = 1);
		foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, gaps);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		in_valid <= 1'b0;
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == ADDR_CATEGORY) cat_reg = data[7:0]; else pass_reg = data[0];
	endtask

	// builds a block with random content, cut short inside its fields when trim is set; sizes kept small
	function automatic void build_block(ref logic [7:0] q[$], input bit trim);
		logic [7:0] f1, f2, body[$], n;
		int len;
		f1 = 8'hC0 | 8'($urandom_range(0, 63) << 1);
		f2 = 8'($urandom_range(0, 127) << 1);
		if ($urandom_range(0, 3) == 0) f2 = 0;
		f1[0] = f2 != 0;
		body = {};
		for (int k = 0; k < NFRN; k++) begin
			if (!((k < 7 ? f1 : f2) & (8'h80 >> (k < 7 ? k : k - 7)))) continue;
			case (k)
				3, 12, 13: begin
					n = $urandom_range(0, 4);
					body.push_back(n);
					repeat (n) body.push_back($urandom);
				end
				8, 9, 10: begin
					n = k == 8 ? $urandom_range(0, 3) : ($urandom_range(0, 4) == 0);
					if (k == 10 && $urandom_range(0, 3) != 0) n = 0;
					body.push_back(n);
					repeat (n * (k == 8 ? 4 : (k == 9 ? 64 : 256))) body.push_back($urandom);
				end
				default: repeat (frn_size(4'(k))) body.push_back($urandom);
			endcase
		end
		if (trim && body.size() > 0) body = body[0:$urandom_range(0, body.size() - 1)];
		len = 3 + (f1[0] ? 2 : 1) + body.size();
		q = {cat_reg, 8'(len >> 8), 8'(len)};
		q.push_back(f1);
		if (f1[0]) q.push_back(f2);
		q = {q, body};
		repeat ($urandom_range(0, 2)) q.push_back($urandom);
	endfunction

	task automatic test_directed_errors();
		send_bytes({cat_reg});
		send_bytes({cat_reg, 8'h00});
		send_bytes({~cat_reg, 8'h00, 8'h05, 8'hC0, 8'h00});
		send_bytes({cat_reg, 8'h00, 8'h03, 8'h00});
		send_bytes({cat_reg, 8'hFF, 8'hFF, 8'hC0, 8'h00});
		send_bytes({cat_reg, 8'h00, 8'h05, 8'h41, 8'h00});
		send_bytes({cat_reg, 8'h00, 8'h05, 8'hC1, 8'h01});
		send_bytes({cat_reg, 8'h00, 8'h04, 8'hC1, 8'h00});
		send_bytes({cat_reg, 8'h00, 8'h05, 8'hC0, 8'hFF});
	endtask

	task automatic test_directed_full();
		// all FRNs set, an empty summary, extremes of byte values; ends early in the femto field
		send_bytes({cat_reg, 8'h00, 8'h2C, 8'hFF, 8'hFE,
			8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h80, 8'h7F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
			8'h09, 8'h0A, 8'h0B, 8'h0C, 8'hFF});
	endtask

	task automatic test_random_blocks(int n_bytes, bit gaps);
		logic [7:0] q[$];
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			case ($urandom_range(0, 9))
				0: begin
					q = {};
					repeat ($urandom_range(1, 8)) q.push_back($urandom);
				end
				1: build_block(q, 1);
				default: build_block(q, 0);
			endcase
			send_bytes(q, gaps);
			sent += q.size();
		end
	endtask

	// receiver held off while a block with many results is offered, so the
	// result queue fills and the input stalls
	task automatic test_backpressure();
		hold_rx = 1;
		fork
			begin
				repeat (60) @(negedge clk);
				hold_rx = 0;
			end
			test_directed_full();
		join
		drain();
	endtask

	task automatic test_config();
		apb_write(ADDR_PASS, 0);
		test_random_blocks(150, 1);
		drain();
		apb_write(ADDR_CATEGORY, 8'h00);
		test_directed_full();
		test_random_blocks(100, 1);
		drain();
		apb_write(ADDR_CATEGORY, 8'hFF);
		apb_write(ADDR_PASS, 1);
		test_random_blocks(100, 1);
		drain();
		apb_write(ADDR_CATEGORY, CATEGORY_RESET);
	endtask

	// result checker: compares each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_item);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (out_item !== want) begin
					$display("%0t mismatch code exp %0d act %0d value exp %h act %h",
						$time, want.item_code, out_item.item_code,
						want.item_value, out_item.item_value);
					$display("%0t   status exp %0d act %0d end exp %b act %b", $time,
						want.parse_status, out_item.parse_status,
						want.record_end, out_item.record_end);
					errors++;
				end
			end
		end
	end

	// receiver stall: random bursts, or held off for a long stretch
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_rx) out_stall <= 1;
			else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else out_stall <= 0;
		end
	end

	initial begin
		errors = 0;
		rx_idle_en = 1;
		hold_rx = 0;
		in_valid = 0;
		in_item = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		cat_reg = CATEGORY_RESET;
		pass_reg = 1;
		clear_parse();
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed_errors();
		test_directed_full();
		drain();
		test_backpressure();
		test_config();
		test_random_blocks(1400, 1);
		drain();
		rx_idle_en = 0;
		test_random_blocks(300, 0);
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
